/* src/lpfr_pkg.sv */
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared types and constants for the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package lpfr_pkg;

  // Default geometry of the slot ring
  localparam int BUFFER_BYTES_DEF = 328;
  localparam int SLOT_COUNT_DEF   = 4;

  // Configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD = 8'd1;

  localparam logic [7:0] START_BYTE_RST  = 8'h61;
  localparam logic [8:0] MAX_PAYLOAD_RST = 9'd324;

  // Header bytes in front of the payload: start, length hi, length lo, type
  localparam int HDR_BYTES = 4;

  // Packed stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 40;

  // One received word
  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  // One result word
  typedef struct packed {
    logic       write_enable;
    logic [1:0] write_slot;
    logic [8:0] write_offset;
    logic [7:0] write_data;
    logic       frame_done;
    logic [8:0] frame_bytes;
    logic       frame_rejected;
    logic       ring_full;
    logic [1:0] read_slot;
    logic [1:0] frames_waiting;
  } result_t;

  // Configuration write
  typedef struct packed {
    logic                   wr;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_wr_t;

endpackage

/* src/length_prefixed_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_top
// Path: each input word passes the input register, the combinational parser
// and the result buffer before its result word can be taken.
// Throughput: one word per cycle when not stalled; the parser updates once per word.
// Stalls: input register and result buffer hold three words before in_tready drops.
// Reset: synchronous, active low; parser idle, slots 0, registers to defaults.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver_top
  import lpfr_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int SLOT_COUNT   = SLOT_COUNT_DEF
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [0] mode
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] write_enable, [2:1] write_slot,
                                             // [11:3] write_offset, [19:12] write_data,
                                             // [28:20] frame_bytes, [29] frame_rejected,
                                             // [30] ring_full, [32:31] read_slot,
                                             // [34:33] frames_waiting, [39:35] zero
  output logic                   out_tlast,  // frame_done
  // Configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  in_item_t in_item;
  in_item_t core_item;
  logic     core_valid;
  logic     buf_not_full;
  logic     step;
  result_t  core_res;
  result_t  out_res;
  cfg_wr_t  cfg;

  assign in_item.mode      = in_tuser[0];
  assign in_item.data_byte = in_tdata[7:0];

  // Configuration is always accepted
  assign cfg_ready = 1'b1;
  assign cfg.wr    = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  lpfr_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_item  (in_item),
    .dn_valid (core_valid),
    .dn_ready (buf_not_full),
    .dn_item  (core_item)
  );

  // A word is parsed when the result buffer has room
  assign step = core_valid && buf_not_full;

  lpfr_core #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .SLOT_COUNT   (SLOT_COUNT)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (step),
    .item  (core_item),
    .res   (core_res)
  );

  lpfr_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (step),
    .push_res (core_res),
    .not_full (buf_not_full),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_res   (out_res)
  );

  // Result word packing
  assign out_tdata = {5'd0,
                      out_res.frames_waiting,
                      out_res.read_slot,
                      out_res.ring_full,
                      out_res.frame_rejected,
                      out_res.frame_bytes,
                      out_res.write_data,
                      out_res.write_offset,
                      out_res.write_slot,
                      out_res.write_enable};
  assign out_tlast = out_res.frame_done;

endmodule

/* src/lpfr_in_reg.sv */
// ----------------------------------------------------------------------------
// lpfr_in_reg
// Input register: holds one received word until the core consumes it.
// ----------------------------------------------------------------------------
module lpfr_in_reg
  import lpfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  in_item_t up_item,
  output logic     dn_valid,
  input  logic     dn_ready,
  output in_item_t dn_item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // Free when empty or when the held word leaves this cycle
  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = (up_valid && up_ready) || (valid_r && !dn_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      item_r <= up_item;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

/* src/lpfr_core.sv */
// ----------------------------------------------------------------------------
// lpfr_core
// Frame parser state, slot ring pointers and configuration registers.
// Computes one result word per consumed input word.
// ----------------------------------------------------------------------------
module lpfr_core
  import lpfr_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int SLOT_COUNT   = SLOT_COUNT_DEF
)
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_wr_t  cfg,
  input  logic     step,
  input  in_item_t item,
  output result_t  res
);

  localparam int OFF_W     = $clog2(BUFFER_BYTES);
  localparam int SLOT_W    = $clog2(SLOT_COUNT);
  localparam int LIMIT_CAP = BUFFER_BYTES - HDR_BYTES;

  // Parser phases
  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_LEN_HI  = 3'd1;
  localparam logic [2:0] PH_LEN_LO  = 3'd2;
  localparam logic [2:0] PH_TYPE    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]        phase_r, phase_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [SLOT_W-1:0] widx_r, widx_nxt;
  logic [SLOT_W-1:0] ridx_r, ridx_nxt;
  logic [7:0]        start_byte_r;
  logic [8:0]        max_payload_r;

  logic [15:0]       limit;
  logic              store;
  logic              complete;
  logic              reject;
  logic              full;
  logic [OFF_W-1:0]  woff;
  logic [SLOT_W-1:0] wnext;
  logic [SLOT_W-1:0] rnext;
  logic [SLOT_W:0]   waiting;
  logic [OFF_W+9:0]  woff_ext;
  logic [OFF_W+9:0]  fbytes_ext;
  logic [SLOT_W+1:0] wslot_ext;
  logic [SLOT_W+1:0] rslot_ext;
  logic [SLOT_W+1:0] wait_ext;

  // Effective length limit, capped so a frame always fits its slot
  always_comb begin
    if ({7'd0, max_payload_r} > 16'(LIMIT_CAP)) begin
      limit = 16'(LIMIT_CAP);
    end else begin
      limit = {7'd0, max_payload_r};
    end
  end

  // Ring neighbors
  assign wnext = (widx_r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : widx_r + 1'b1;
  assign rnext = (ridx_r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : ridx_r + 1'b1;

  // Store offset restarts on the start byte
  assign woff = (phase_r == PH_START) ? '0 : off_r;

  // Per-word parser update
  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    off_nxt   = off_r;
    widx_nxt  = widx_r;
    ridx_nxt  = ridx_r;
    store     = 1'b0;
    complete  = 1'b0;
    reject    = 1'b0;
    full      = 1'b0;
    if (item.mode) begin
      // Consumer release
      if (ridx_r != widx_r) begin
        ridx_nxt = rnext;
      end
    end else begin
      store = 1'b1;
      unique case (phase_r)
        PH_START: begin
          if (item.data_byte == start_byte_r) begin
            phase_nxt = PH_LEN_HI;
          end else begin
            store = 1'b0;
          end
        end
        PH_LEN_HI: begin
          rem_nxt   = {8'd0, item.data_byte};
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          rem_nxt = {rem_r[7:0], item.data_byte};
          if ({rem_r[7:0], item.data_byte} > limit) begin
            reject    = 1'b1;
            phase_nxt = PH_START;
          end else begin
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (rem_r == '0) begin
            complete = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          rem_nxt = rem_r - 1'b1;
          if (rem_r == 16'd1) begin
            complete = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_START;
          store     = 1'b0;
        end
      endcase

      // Offset saturates at the last byte of the slot
      if (store) begin
        if (woff == OFF_W'(BUFFER_BYTES - 1)) begin
          off_nxt = woff;
        end else begin
          off_nxt = woff + 1'b1;
        end
      end

      // Completion advances the write slot unless the ring is full
      if (complete) begin
        phase_nxt = PH_START;
        if (wnext == ridx_r) begin
          full = 1'b1;
        end else begin
          widx_nxt = wnext;
        end
      end
    end
  end

  // Complete frames between read and write slot after this word
  always_comb begin
    if (widx_nxt >= ridx_nxt) begin
      waiting = (SLOT_W+1)'(widx_nxt) - (SLOT_W+1)'(ridx_nxt);
    end else begin
      waiting = (SLOT_W+1)'(widx_nxt) + (SLOT_W+1)'(SLOT_COUNT) - (SLOT_W+1)'(ridx_nxt);
    end
  end

  // Fit internal widths to the fixed result fields
  assign woff_ext   = (OFF_W+10)'(woff);
  assign fbytes_ext = woff_ext + 1'b1;
  assign wslot_ext  = (SLOT_W+2)'(widx_r);
  assign rslot_ext  = (SLOT_W+2)'(ridx_nxt);
  assign wait_ext   = (SLOT_W+2)'(waiting);

  always_comb begin
    res.write_enable   = store;
    res.write_slot     = wslot_ext[1:0];
    res.write_offset   = store ? woff_ext[8:0] : 9'd0;
    res.write_data     = store ? item.data_byte : 8'd0;
    res.frame_done     = complete;
    res.frame_bytes    = complete ? fbytes_ext[8:0] : 9'd0;
    res.frame_rejected = reject;
    res.ring_full      = full;
    res.read_slot      = rslot_ext[1:0];
    res.frames_waiting = wait_ext[1:0];
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      rem_r   <= '0;
      off_r   <= '0;
      widx_r  <= '0;
      ridx_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      off_r   <= off_nxt;
      widx_r  <= widx_nxt;
      ridx_r  <= ridx_nxt;
    end
  end

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r  <= START_BYTE_RST;
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg.wr) begin
      unique case (cfg.index)
        CFG_START_BYTE:  start_byte_r  <= cfg.data[7:0];
        CFG_MAX_PAYLOAD: max_payload_r <= cfg.data[8:0];
        default: ;
      endcase
    end
  end

endmodule

/* src/lpfr_out_buf.sv */
// ----------------------------------------------------------------------------
// lpfr_out_buf
// Two-entry result buffer: keeps full rate until both entries fill while the consumer stalls.
// ----------------------------------------------------------------------------
module lpfr_out_buf
  import lpfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_res,
  output logic    not_full,
  output logic    dn_valid,
  input  logic    dn_ready,
  output result_t dn_res
);

  result_t    mem [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign not_full = (cnt_r != 2'd2);
  assign dn_valid = (cnt_r != 2'd0);
  assign pop      = dn_valid && dn_ready;
  assign dn_res   = mem[rp_r];

  // Pointer and count update
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop  ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Result storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_res;
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the length-prefixed frame receiver. Words (bytes and
// consumer releases) are queued by the stimulus block and driven by a
// handshake driver with random gaps. Each accepted word runs through a local
// parser model that predicts the slot write report. The receiver side stalls
// at random, and once for a long stretch to back up the input. Every result
// word is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import lpfr_pkg::*;

  localparam int  WATCHDOG_LIMIT   = 2000;
  localparam int  MAX_ERROR_LINES  = 100;
  localparam int  BUF_BYTES        = BUFFER_BYTES_DEF;
  localparam int  SLOTS            = SLOT_COUNT_DEF;
  localparam int  LIMIT_CAP        = BUF_BYTES - HDR_BYTES;

  // Input word kinds carried on tuser
  localparam logic MODE_BYTE    = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // Register indexes past the defined ones
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNUSED = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAST_INDEX   = 8'hFF;

  typedef enum logic [2:0] {
    PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_TYPE, PH_BODY
  } parse_phase_e;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  length_prefixed_frame_receiver_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Stimulus queue and bookkeeping
  in_item_t   rx_words_q[$];
  result_t    slot_writes_q[$];
  int         issued_count   = 0;
  int         accepted_count = 0;
  int         checked_count  = 0;
  int         error_count    = 0;
  int         idle_cycles    = 0;

  // Handshake flags, set at the rising edge, consumed at the falling edge
  bit         in_taken  = 1'b0;
  bit         out_taken = 1'b0;
  bit         cfg_taken = 1'b0;

  // Idle control
  int         in_gap_max    = 6;
  int         out_gap_max   = 6;
  int         in_gap        = 0;
  int         out_wait      = 0;
  int         out_hold      = 0;
  int         stall_request = 0;

  // Stimulus-side view of the configuration
  logic [7:0] cur_start = START_BYTE_RST;
  int         cur_limit = MAX_PAYLOAD_RST;

  // Parser model state and its copy of the registers
  parse_phase_e rx_phase      = PH_HUNT;
  logic [15:0]  remaining     = '0;
  logic [8:0]   frame_offset  = '0;
  logic [1:0]   wr_slot       = '0;
  logic [1:0]   rd_slot       = '0;
  logic [7:0]   start_sh      = START_BYTE_RST;
  logic [8:0]   max_payload_sh = MAX_PAYLOAD_RST;

  in_item_t   drive_word;
  in_item_t   seen_word;
  result_t    got;
  result_t    want;

  function automatic logic [1:0] next_slot(logic [1:0] s);
    return (int'(s) + 1 >= SLOTS) ? 2'd0 : s + 2'd1;
  endfunction

  // Advance the parser model by one word and build the slot write report
  function automatic result_t parse_rx_word(in_item_t w);
    result_t r;
    int      lim;
    bit      store;
    bit      complete;
    r        = '0;
    store    = 1'b1;
    complete = 1'b0;
    r.write_slot = wr_slot;
    lim = (int'(max_payload_sh) > LIMIT_CAP) ? LIMIT_CAP : int'(max_payload_sh);
    if (w.mode == MODE_RELEASE) begin
      if (rd_slot != wr_slot) rd_slot = next_slot(rd_slot);
    end else begin
      case (rx_phase)
        PH_HUNT: begin
          if (w.data_byte == start_sh) begin
            frame_offset = '0;
            rx_phase     = PH_LEN_HI;
          end else begin
            store = 1'b0;
          end
        end
        PH_LEN_HI: begin
          remaining = {8'h00, w.data_byte};
          rx_phase  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          remaining = {remaining[7:0], w.data_byte};
          if (int'(remaining) > lim) begin
            r.frame_rejected = 1'b1;
            rx_phase         = PH_HUNT;
          end else begin
            rx_phase = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (remaining == 16'd0) complete = 1'b1;
          else rx_phase = PH_BODY;
        end
        default: begin
          remaining = remaining - 16'd1;
          if (remaining == 16'd0) complete = 1'b1;
        end
      endcase
      if (store) begin
        r.write_enable = 1'b1;
        r.write_offset = frame_offset;
        r.write_data   = w.data_byte;
        if (int'(frame_offset) + 1 < BUF_BYTES) frame_offset = frame_offset + 9'd1;
      end
      // Completion: advance the write slot unless it would hit the read slot
      if (complete) begin
        r.frame_done  = 1'b1;
        r.frame_bytes = r.write_offset + 9'd1;
        if (next_slot(wr_slot) == rd_slot) r.ring_full = 1'b1;
        else wr_slot = next_slot(wr_slot);
        rx_phase = PH_HUNT;
      end
    end
    r.read_slot      = rd_slot;
    r.frames_waiting = 2'((int'(wr_slot) + SLOTS - int'(rd_slot)) % SLOTS);
    return r;
  endfunction

  task automatic report_error(string msg);
    if (error_count < MAX_ERROR_LINES) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int unsigned g, int unsigned w);
    if (g != w)
      report_error($sformatf("word %0d: %s = %0d, expected %0d", checked_count, name, g, w));
  endtask

  // Rising edge: take handshakes, predict, check, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_START_BYTE) start_sh = cfg_data[7:0];
        else if (cfg_index == CFG_MAX_PAYLOAD) max_payload_sh = cfg_data;
        cfg_taken = 1'b1;
      end
      if (in_tvalid && in_tready) begin
        seen_word.mode      = in_tuser[0];
        seen_word.data_byte = in_tdata;
        slot_writes_q.push_back(parse_rx_word(seen_word));
        accepted_count++;
        in_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        got.write_enable   = out_tdata[0];
        got.write_slot     = out_tdata[2:1];
        got.write_offset   = out_tdata[11:3];
        got.write_data     = out_tdata[19:12];
        got.frame_done     = out_tlast;
        got.frame_bytes    = out_tdata[28:20];
        got.frame_rejected = out_tdata[29];
        got.ring_full      = out_tdata[30];
        got.read_slot      = out_tdata[32:31];
        got.frames_waiting = out_tdata[34:33];
        if (slot_writes_q.size() == 0) begin
          report_error($sformatf("word %0d: result with nothing predicted", checked_count));
        end else begin
          want = slot_writes_q.pop_front();
          check_field("write_enable",   got.write_enable,   want.write_enable);
          check_field("write_slot",     got.write_slot,     want.write_slot);
          check_field("write_offset",   got.write_offset,   want.write_offset);
          check_field("write_data",     got.write_data,     want.write_data);
          check_field("frame_done",     got.frame_done,     want.frame_done);
          check_field("frame_bytes",    got.frame_bytes,    want.frame_bytes);
          check_field("frame_rejected", got.frame_rejected, want.frame_rejected);
          check_field("ring_full",      got.ring_full,      want.ring_full);
          check_field("read_slot",      got.read_slot,      want.read_slot);
          check_field("frames_waiting", got.frames_waiting, want.frames_waiting);
          check_field("tdata padding",  out_tdata[39:35],   0);
        end
        checked_count++;
        out_taken = 1'b1;
      end
      // Watchdog on cycles with no handshake at all
      if ((cfg_valid && cfg_ready) || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Input driver: one word at a time, random gap after each accepted word
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_gap   = $urandom_range(0, in_gap_max);
      end
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (rx_words_q.size() > 0) begin
        drive_word = rx_words_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= drive_word.data_byte;
        in_tuser  <= drive_word.mode;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random wait per word, plus a long hold on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        out_taken = 1'b0;
        out_wait  = $urandom_range(0, out_gap_max);
      end
      if (stall_request > 0) begin
        out_hold      = stall_request;
        stall_request = 0;
      end
      if (out_hold > 0) begin
        out_hold--;
        out_tready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_word(logic mode, logic [7:0] b);
    in_item_t w;
    w.mode      = mode;
    w.data_byte = b;
    rx_words_q.push_back(w);
    issued_count++;
  endtask

  // Header, then type and payload if the length is within the limit
  task automatic push_frame(int len);
    push_word(MODE_BYTE, cur_start);
    push_word(MODE_BYTE, len[15:8]);
    push_word(MODE_BYTE, len[7:0]);
    if (len <= cur_limit) begin
      push_word(MODE_BYTE, 8'($urandom));
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) < 4) push_word(MODE_RELEASE, 8'($urandom));
        push_word(MODE_BYTE, 8'($urandom));
      end
    end
  endtask

  // Mostly well-formed frames and releases, some noise, over-long lengths and cut-off headers
  task automatic gen_traffic(int n, int lenmax);
    int         target;
    int         kind;
    int         top;
    logic [7:0] b;
    target = issued_count + n;
    top    = (lenmax < cur_limit) ? lenmax : cur_limit;
    while (issued_count < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        b = 8'($urandom);
        if (b == cur_start) b = ~b;
        push_word(MODE_BYTE, b);
      end else if (kind < 35) begin
        push_word(MODE_RELEASE, 8'($urandom));
      end else if (kind < 41) begin
        push_word(MODE_BYTE, cur_start);
        repeat ($urandom_range(1, 2)) push_word(MODE_BYTE, 8'($urandom));
      end else if (kind < 50) begin
        push_frame($urandom_range(cur_limit + 1, 65535));
      end else begin
        push_frame($urandom_range(0, top));
      end
    end
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_taken = 1'b0;
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [8:0] start_raw, logic [8:0] max_raw);
    cfg_write(CFG_START_BYTE, start_raw);
    cfg_write(CFG_MAX_PAYLOAD, max_raw);
    cur_start = start_raw[7:0];
    cur_limit = (int'(max_raw) > LIMIT_CAP) ? LIMIT_CAP : int'(max_raw);
  endtask

  // Wait until every word is taken and every result checked, then pause
  task automatic settle(int tail);
    while (accepted_count != issued_count || slot_writes_q.size() != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: noise, empty release, zero length, rejects, short frames
    push_word(MODE_BYTE, 8'h00);
    push_word(MODE_RELEASE, 8'hFF);
    push_frame(0);
    push_frame(16'hFFFF);
    push_frame(LIMIT_CAP + 1);
    push_frame(2);
    push_word(MODE_RELEASE, 8'h00);
    // release in the middle of a frame
    push_word(MODE_BYTE, cur_start);
    push_word(MODE_BYTE, 8'h00);
    push_word(MODE_BYTE, 8'h01);
    push_word(MODE_BYTE, 8'h5A);
    push_word(MODE_RELEASE, 8'hA5);
    push_word(MODE_BYTE, 8'hFF);
    settle(4);

    // Lowest settings: start byte zero, only empty frames fit
    configure(9'h000, 9'd0);
    gen_traffic(16, 3);
    settle(4);

    // Highest settings: limit above the buffer acts as the buffer limit
    configure(9'h1FF, 9'h1FF);
    cfg_write(CFG_FIRST_UNUSED, 9'h1AA);
    cfg_write(CFG_LAST_INDEX, 9'h055);
    push_frame(LIMIT_CAP);
    push_frame(LIMIT_CAP + 1);
    gen_traffic(10, 12);
    settle(4);

    // Long receiver hold with the sender running flat out
    in_gap_max    = 0;
    stall_request = 300;
    gen_traffic(24, 8);
    settle(4);

    // No idling on either side, random registers
    out_gap_max = 0;
    configure(9'($urandom_range(0, 511)), 9'($urandom_range(1, 40)));
    gen_traffic(16, 40);
    settle(4);

    // Back to random gaps, limit written at exactly the buffer limit
    in_gap_max  = 6;
    out_gap_max = 6;
    configure({1'b0, START_BYTE_RST}, 9'd324);
    gen_traffic(12, 16);
    settle(8);

    if (error_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
